// ===== hw/rtl/hcpp_pkg.sv =====
`default_nettype none

package hcpp_pkg;

  // curve parameter resolution, t = sample_index / STEPS
  localparam int STEPS_LG = 10;
  localparam int STEPS    = 1 << STEPS_LG;

  localparam int IN_W  = 11;
  localparam int CFG_W = 16;
  localparam int COL_W = 4;
  localparam int PIX_W = 16;
  localparam int IDX_W = 3;

  localparam int CURVE_FRAC = 12;
  localparam int PIXEL_FRAC = 38;

  // horner datapath widths (bounded by the input ranges)
  localparam int COEF_W = IN_W + 4;
  localparam int U1_W   = COEF_W + STEPS_LG;
  localparam int U2_W   = U1_W + STEPS_LG + 1;
  localparam int U3_W   = U2_W + STEPS_LG + 1;
  localparam int Q_SH   = 3 * STEPS_LG - CURVE_FRAC;
  localparam int Q_W    = IN_W + CURVE_FRAC + 1;

  // rotation and scaling widths
  localparam int PROD_W = Q_W + CFG_W;
  localparam int ROT_W  = PROD_W + 1;
  localparam int SCL_W  = ROT_W + CFG_W;
  localparam int TOT_W  = SCL_W + 1;

  localparam int PIX_MAX = (1 << (PIX_W - 1)) - 1;
  localparam int PIX_MIN = -(1 << (PIX_W - 1));

  // pipeline stage map
  localparam int AXIS_ST = 5;
  localparam int ST_PROD = AXIS_ST;
  localparam int ST_ROT  = AXIS_ST + 1;
  localparam int ST_SCL  = AXIS_ST + 2;
  localparam int ST_OUT  = AXIS_ST + 3;
  localparam int NUM_ST  = ST_OUT + 1;

  typedef enum logic [IDX_W-1:0] {
    REG_COS    = 3'd0,
    REG_SIN    = 3'd1,
    REG_HSCALE = 3'd2,
    REG_VSCALE = 3'd3,
    REG_CX     = 3'd4,
    REG_CY     = 3'd5,
    REG_COLOUR = 3'd6
  } cfg_reg_e;

  localparam logic signed [CFG_W-1:0] COS_RST    = 16'sd16384;
  localparam logic signed [CFG_W-1:0] SIN_RST    = 16'sd0;
  localparam logic signed [CFG_W-1:0] SCALE_RST  = 16'sd4096;
  localparam logic signed [CFG_W-1:0] CENTER_RST = 16'sd0;
  localparam logic [COL_W-1:0]        COLOUR_RST = 4'd15;

endpackage

`default_nettype wire

// ===== hw/rtl/hcpp_stream_if.sv =====
`default_nettype none

interface hcpp_seg_if import hcpp_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] start_x;
  logic signed [IN_W-1:0] start_y;
  logic signed [IN_W-1:0] end_x;
  logic signed [IN_W-1:0] end_y;
  logic signed [IN_W-1:0] start_tangent_x;
  logic signed [IN_W-1:0] start_tangent_y;
  logic signed [IN_W-1:0] end_tangent_x;
  logic signed [IN_W-1:0] end_tangent_y;
  logic        [IN_W-1:0] sample_index;

  modport source (
    output valid, start_x, start_y, end_x, end_y, start_tangent_x, start_tangent_y,
           end_tangent_x, end_tangent_y, sample_index,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, end_x, end_y, start_tangent_x, start_tangent_y,
           end_tangent_x, end_tangent_y, sample_index,
    output ready
  );
endinterface

interface hcpp_pix_if import hcpp_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic        [COL_W-1:0] pixel_colour;

  modport source (
    output valid, pixel_x, pixel_y, pixel_colour,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_colour,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/hcpp_axis.sv =====
`default_nettype none

// one coordinate of the hermite segment, horner form in k, result in q.12
module hcpp_axis import hcpp_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic [AXIS_ST-1:0]      en_i,
  input  wire logic signed [IN_W-1:0]  p0_i,
  input  wire logic signed [IN_W-1:0]  p1_i,
  input  wire logic signed [IN_W-1:0]  r0_i,
  input  wire logic signed [IN_W-1:0]  r1_i,
  input  wire logic [IN_W-1:0]         k_i,
  output logic signed [Q_W-1:0]        q_o
);

  localparam logic signed [U3_W-1:0] Q_RND = U3_W'((64'd1 << Q_SH) - 64'd1);

  logic signed [COEF_W-1:0] p0_e, p1_e, r0_e, r1_e, dp_e;
  logic signed [COEF_W-1:0] a_d, a_q, b_d, b_q;
  logic signed [IN_W-1:0]   c0_q, c1_q, d0_q, d1_q, d2_q;
  logic [IN_W-1:0]          k0_q, k1_q, k2_q;
  logic signed [IN_W:0]     ks0, ks1, ks2;
  logic signed [U1_W-1:0]   u1_d, u1_q;
  logic signed [U2_W-1:0]   u2_d, u2_q;
  logic signed [U3_W-1:0]   u3_d, u3_q, u3_adj, u3_sh;
  logic signed [Q_W-1:0]    q_d, q_q;

  // polynomial coefficients: a k^3 + b s k^2 + r0 s^2 k + p0 s^3
  always_comb begin
    p0_e = COEF_W'(p0_i);
    p1_e = COEF_W'(p1_i);
    r0_e = COEF_W'(r0_i);
    r1_e = COEF_W'(r1_i);
    dp_e = p1_e - p0_e;
    a_d  = r0_e + r1_e - (dp_e <<< 1);
    b_d  = (dp_e <<< 1) + dp_e - (r0_e <<< 1) - r1_e;
  end

  assign ks0 = $signed({1'b0, k0_q});
  assign ks1 = $signed({1'b0, k1_q});
  assign ks2 = $signed({1'b0, k2_q});

  always_comb begin
    u1_d   = U1_W'(a_q) * U1_W'(ks0) + (U1_W'(b_q) <<< STEPS_LG);
    u2_d   = U2_W'(u1_q) * U2_W'(ks1) + (U2_W'(c1_q) <<< (2 * STEPS_LG));
    u3_d   = U3_W'(u2_q) * U3_W'(ks2) + (U3_W'(d2_q) <<< (3 * STEPS_LG));
    // truncate toward zero
    u3_adj = u3_q + (u3_q[U3_W-1] ? Q_RND : '0);
    u3_sh  = u3_adj >>> Q_SH;
    q_d    = u3_sh[Q_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q  <= a_d;
      b_q  <= b_d;
      c0_q <= r0_i;
      d0_q <= p0_i;
      k0_q <= k_i;
    end
    if (en_i[1]) begin
      u1_q <= u1_d;
      c1_q <= c0_q;
      d1_q <= d0_q;
      k1_q <= k0_q;
    end
    if (en_i[2]) begin
      u2_q <= u2_d;
      d2_q <= d1_q;
      k2_q <= k1_q;
    end
    if (en_i[3]) begin
      u3_q <= u3_d;
    end
    if (en_i[4]) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hermite_curve_point_plotter.sv =====
`default_nettype none

// channel  | dir | payload                                             | beat
// ---------+-----+-----------------------------------------------------+---------------
// seg_i    | in  | segment points, tangents, sample_index              | valid & ready
// pix_o    | out | pixel_x, pixel_y, pixel_colour                      | valid & ready
// cfg_*    | in  | register index, write data                          | cfg_we_i
//
// nine register stages, one beat in and one beat out per cycle while pix_o is ready
// stages: coefficient stage, three horner multiply-add stages in k, the q.12 cut per axis,
// then rotation products, rotation sum, axis scaling and the saturating output stage
// reset clears the stage valid bits and loads the register defaults, datapath is unreset
// stalls collapse bubbles: a stage moves when it is empty or its successor moves,
// so seg_i.ready drops only with every stage full and pix_o stalled
module hermite_curve_point_plotter import hcpp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  hcpp_seg_if.sink              seg_i,
  hcpp_pix_if.source            pix_o,
  input  wire logic             cfg_we_i,
  input  wire logic [IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  localparam logic [IN_W-1:0] K_MAX = IN_W'(STEPS);
  localparam logic signed [TOT_W-1:0] T_RND = TOT_W'((64'd1 << PIXEL_FRAC) - 64'd1);

  // configuration registers
  logic signed [CFG_W-1:0] cos_q, sin_q, hscale_q, vscale_q, cx_q, cy_q;
  logic [COL_W-1:0]        colour_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q    <= COS_RST;
      sin_q    <= SIN_RST;
      hscale_q <= SCALE_RST;
      vscale_q <= SCALE_RST;
      cx_q     <= CENTER_RST;
      cy_q     <= CENTER_RST;
      colour_q <= COLOUR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_COS:    cos_q    <= cfg_data_i;
        REG_SIN:    sin_q    <= cfg_data_i;
        REG_HSCALE: hscale_q <= cfg_data_i;
        REG_VSCALE: vscale_q <= cfg_data_i;
        REG_CX:     cx_q     <= cfg_data_i;
        REG_CY:     cy_q     <= cfg_data_i;
        REG_COLOUR: colour_q <= cfg_data_i[COL_W-1:0];
        default:    ; // unmapped index, write dropped
      endcase
    end
  end

  // stage handshake: valid bits ride along, enables ripple back from the output
  logic [NUM_ST-1:0] valid_q, valid_d, en;

  always_comb begin
    en[NUM_ST-1] = !valid_q[NUM_ST-1] || pix_o.ready;
    for (int i = NUM_ST - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
    valid_d[0] = en[0] ? seg_i.valid : valid_q[0];
    for (int i = 1; i < NUM_ST; i++) begin
      valid_d[i] = en[i] ? valid_q[i-1] : valid_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign seg_i.ready = en[0];

  // sample index past the end of the segment clamps to t = 1
  logic [IN_W-1:0] k_clamp;
  assign k_clamp = (seg_i.sample_index > K_MAX) ? K_MAX : seg_i.sample_index;

  // curve point in q.12, stages 0 to 4
  logic signed [Q_W-1:0] xq, yq;

  hcpp_axis u_axis_x (
    .clk_i (clk_i),
    .en_i  (en[AXIS_ST-1:0]),
    .p0_i  (seg_i.start_x),
    .p1_i  (seg_i.end_x),
    .r0_i  (seg_i.start_tangent_x),
    .r1_i  (seg_i.end_tangent_x),
    .k_i   (k_clamp),
    .q_o   (xq)
  );

  hcpp_axis u_axis_y (
    .clk_i (clk_i),
    .en_i  (en[AXIS_ST-1:0]),
    .p0_i  (seg_i.start_y),
    .p1_i  (seg_i.end_y),
    .r0_i  (seg_i.start_tangent_y),
    .r1_i  (seg_i.end_tangent_y),
    .k_i   (k_clamp),
    .q_o   (yq)
  );

  // rotation products, q.26
  logic signed [PROD_W-1:0] xc_q, ys_q, xs_q, yc_q;
  logic signed [ROT_W-1:0]  rx_d, ry_d, rx_q, ry_q;
  logic signed [SCL_W-1:0]  mx_d, my_d, mx_q, my_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_PROD]) begin
      xc_q <= PROD_W'(xq) * PROD_W'(cos_q);
      ys_q <= PROD_W'(yq) * PROD_W'(sin_q);
      xs_q <= PROD_W'(xq) * PROD_W'(sin_q);
      yc_q <= PROD_W'(yq) * PROD_W'(cos_q);
    end
  end

  always_comb begin
    rx_d = ROT_W'(xc_q) - ROT_W'(ys_q);
    ry_d = ROT_W'(xs_q) + ROT_W'(yc_q);
    mx_d = SCL_W'(rx_q) * SCL_W'(hscale_q);
    my_d = SCL_W'(ry_q) * SCL_W'(vscale_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_ROT]) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
    end
    if (en[ST_SCL]) begin
      mx_q <= mx_d;
      my_q <= my_d;
    end
  end

  // add the center in q.38, truncate toward zero, clip to 16 bits
  logic signed [TOT_W-1:0] tx, ty, tx_sh, ty_sh;
  logic signed [PIX_W-1:0] px_d, py_d, px_q, py_q;
  logic [COL_W-1:0]        col_q;

  always_comb begin
    tx    = (TOT_W'(cx_q) <<< PIXEL_FRAC) + TOT_W'(mx_q);
    ty    = (TOT_W'(cy_q) <<< PIXEL_FRAC) + TOT_W'(my_q);
    tx_sh = $signed(tx + (tx[TOT_W-1] ? T_RND : '0)) >>> PIXEL_FRAC;
    ty_sh = $signed(ty + (ty[TOT_W-1] ? T_RND : '0)) >>> PIXEL_FRAC;
    if (tx_sh > TOT_W'(PIX_MAX)) begin
      px_d = PIX_W'(PIX_MAX);
    end else if (tx_sh < TOT_W'(PIX_MIN)) begin
      px_d = PIX_W'(PIX_MIN);
    end else begin
      px_d = tx_sh[PIX_W-1:0];
    end
    if (ty_sh > TOT_W'(PIX_MAX)) begin
      py_d = PIX_W'(PIX_MAX);
    end else if (ty_sh < TOT_W'(PIX_MIN)) begin
      py_d = PIX_W'(PIX_MIN);
    end else begin
      py_d = ty_sh[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      px_q  <= px_d;
      py_q  <= py_d;
      col_q <= colour_q;
    end
  end

  assign pix_o.valid        = valid_q[ST_OUT];
  assign pix_o.pixel_x      = px_q;
  assign pix_o.pixel_y      = py_q;
  assign pix_o.pixel_colour = col_q;

  // checks
  logic in_beat, out_beat;
  assign in_beat  = seg_i.valid && seg_i.ready;
  assign out_beat = pix_o.valid && pix_o.ready;

  // an accepted beat with nothing leaving adds exactly one item in flight
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni) && $past(in_beat) && !$past(out_beat))
      |-> ($countones(valid_q) == $countones($past(valid_q)) + 1))
    else $error("item count did not grow on an accepted beat");

  // a delivered beat with nothing entering removes exactly one item
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni) && !$past(in_beat) && $past(out_beat))
      |-> ($countones(valid_q) + 1 == $countones($past(valid_q))))
    else $error("item count did not shrink on a delivered beat");

  // backpressure reaches the input only when every stage is full
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seg_i.ready |-> ((&valid_q) && !pix_o.ready))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== dv/tb_hermite_curve_point_plotter.sv =====
`timescale 1ns / 100ps

module tb_hermite_curve_point_plotter;
  import hcpp_pkg::*;

  // run shape
  localparam int PHASES         = 8;
  localparam int PHASE_BEATS    = 200;
  localparam int PRESSURE_PHASE = 3;
  localparam int PRESSURE_BEATS = 40;
  localparam int LONG_HOLD      = 100;
  localparam int DRAIN_CYCLES   = 2 * NUM_ST;

  // index past the register list, writes there must be dropped
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [IN_W-1:0] start_x;
    logic signed [IN_W-1:0] start_y;
    logic signed [IN_W-1:0] end_x;
    logic signed [IN_W-1:0] end_y;
    logic signed [IN_W-1:0] start_tangent_x;
    logic signed [IN_W-1:0] start_tangent_y;
    logic signed [IN_W-1:0] end_tangent_x;
    logic signed [IN_W-1:0] end_tangent_y;
    logic        [IN_W-1:0] sample_index;
  } segment_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic        [COL_W-1:0] pixel_colour;
  } pixel_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] cosine;
    logic signed [CFG_W-1:0] sine;
    logic signed [CFG_W-1:0] hscale;
    logic signed [CFG_W-1:0] vscale;
    logic signed [CFG_W-1:0] cx;
    logic signed [CFG_W-1:0] cy;
    logic        [COL_W-1:0] colour;
  } plot_cfg_t;

  // predicts each plotted pixel and holds them in order until they come out
  class pixel_checker;
    logic signed [CFG_W-1:0] cosine = COS_RST;
    logic signed [CFG_W-1:0] sine   = SIN_RST;
    logic signed [CFG_W-1:0] hscale = SCALE_RST;
    logic signed [CFG_W-1:0] vscale = SCALE_RST;
    logic signed [CFG_W-1:0] cx     = CENTER_RST;
    logic signed [CFG_W-1:0] cy     = CENTER_RST;
    logic        [COL_W-1:0] colour = COLOUR_RST;
    pixel_t expected_pixels[$];
    int failures = 0;

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_COS:    cosine = data;
        REG_SIN:    sine   = data;
        REG_HSCALE: hscale = data;
        REG_VSCALE: vscale = data;
        REG_CX:     cx     = data;
        REG_CY:     cy     = data;
        REG_COLOUR: colour = data[COL_W-1:0];
        default:    ;
      endcase
    endfunction

    // exact num / den cut to q.12, toward zero
    function longint curve_to_q12(longint num, longint den);
      longint q;
      longint r;
      q = num / den;
      r = num % den;
      return q * (longint'(1) <<< CURVE_FRAC) + (r * (longint'(1) <<< CURVE_FRAC)) / den;
    endfunction

    function logic signed [PIX_W-1:0] to_screen(longint centre, longint scaled);
      longint total;
      total = centre * (longint'(1) <<< PIXEL_FRAC) + scaled;
      total = total / (longint'(1) <<< PIXEL_FRAC);
      if (total > PIX_MAX) total = PIX_MAX;
      if (total < PIX_MIN) total = PIX_MIN;
      return total[PIX_W-1:0];
    endfunction

    function pixel_t predict_pixel(segment_t s);
      longint k, k2, k3, span, span2, span3;
      longint h00, h01, h10, h11, xn, yn, xq, yq, rx, ry;
      pixel_t p;
      span  = STEPS;
      span2 = span * span;
      span3 = span2 * span;
      k = longint'(s.sample_index);
      if (k > span) k = span;
      k2 = k * k;
      k3 = k2 * k;
      h00 = 2 * k3 - 3 * k2 * span + span3;
      h01 = -2 * k3 + 3 * k2 * span;
      h10 = k3 - 2 * k2 * span + k * span2;
      h11 = k3 - k2 * span;
      xn = h00 * longint'(s.start_x) + h01 * longint'(s.end_x)
         + h10 * longint'(s.start_tangent_x) + h11 * longint'(s.end_tangent_x);
      yn = h00 * longint'(s.start_y) + h01 * longint'(s.end_y)
         + h10 * longint'(s.start_tangent_y) + h11 * longint'(s.end_tangent_y);
      xq = curve_to_q12(xn, span3);
      yq = curve_to_q12(yn, span3);
      rx = xq * longint'(cosine) - yq * longint'(sine);
      ry = xq * longint'(sine) + yq * longint'(cosine);
      p.pixel_x      = to_screen(longint'(cx), rx * longint'(hscale));
      p.pixel_y      = to_screen(longint'(cy), ry * longint'(vscale));
      p.pixel_colour = colour;
      return p;
    endfunction

    function void note_segment(segment_t s);
      expected_pixels.push_back(predict_pixel(s));
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t unexpected pixel x %0d y %0d colour %0d", $time,
                 got.pixel_x, got.pixel_y, got.pixel_colour);
        failures++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x) begin
        $display("%0t pixel_x expected %0d actual %0d", $time, want.pixel_x, got.pixel_x);
        failures++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $display("%0t pixel_y expected %0d actual %0d", $time, want.pixel_y, got.pixel_y);
        failures++;
      end
      if (got.pixel_colour !== want.pixel_colour) begin
        $display("%0t pixel_colour expected %0d actual %0d", $time,
                 want.pixel_colour, got.pixel_colour);
        failures++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  hcpp_seg_if seg ();
  hcpp_pix_if pix ();

  pixel_checker board;

  // shared between the stimulus thread and the pixel ready thread
  bit quiet;          // no idling on either side
  bit hold_request;   // ask the receiver for one long hold-off

  hermite_curve_point_plotter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .seg_i      (seg),
    .pix_o      (pix),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // segment side helpers
  // ---------------------------------------------------------------------------

  function automatic segment_t make_seg(int sx, int sy, int ex, int ey, int tsx, int tsy,
                                        int tex, int tey, int k);
    segment_t s;
    s.start_x         = sx[IN_W-1:0];
    s.start_y         = sy[IN_W-1:0];
    s.end_x           = ex[IN_W-1:0];
    s.end_y           = ey[IN_W-1:0];
    s.start_tangent_x = tsx[IN_W-1:0];
    s.start_tangent_y = tsy[IN_W-1:0];
    s.end_tangent_x   = tex[IN_W-1:0];
    s.end_tangent_y   = tey[IN_W-1:0];
    s.sample_index    = k[IN_W-1:0];
    return s;
  endfunction

  // full-range fields, sample index mostly inside [0, STEPS]
  function automatic segment_t random_seg();
    segment_t s;
    int pick;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    s = raw[$bits(segment_t)-1:0];
    pick = $urandom_range(0, 7);
    if (pick == 0)      s.sample_index = IN_W'($urandom);
    else if (pick == 1) s.sample_index = ($urandom_range(0, 1) != 0) ? IN_W'(STEPS) : '0;
    else                s.sample_index = IN_W'($urandom_range(0, STEPS));
    // now and then a small start_x and end_y, the other fields stay full range
    if ($urandom_range(0, 3) == 0) begin
      s.start_x = IN_W'($urandom_range(0, 63)) - 11'sd32;
      s.end_y   = IN_W'($urandom_range(0, 63)) - 11'sd32;
    end
    return s;
  endfunction

  // offer one segment beat and hold it until the block takes it
  task automatic send_seg(input segment_t s);
    seg.valid           <= 1'b1;
    seg.start_x         <= s.start_x;
    seg.start_y         <= s.start_y;
    seg.end_x           <= s.end_x;
    seg.end_y           <= s.end_y;
    seg.start_tangent_x <= s.start_tangent_x;
    seg.start_tangent_y <= s.start_tangent_y;
    seg.end_tangent_x   <= s.end_tangent_x;
    seg.end_tangent_y   <= s.end_tangent_y;
    seg.sample_index    <= s.sample_index;
    do @(posedge clk_i); while (seg.ready !== 1'b1);
    board.note_segment(s);
  endtask

  task automatic sender_idle(input int cycles);
    seg.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // sender pauses until every predicted pixel has come out
  task automatic wait_drained();
    seg.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // configuration helpers
  // ---------------------------------------------------------------------------

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  task automatic program_config(input plot_cfg_t c);
    // a write past the list must not disturb anything
    write_reg(REG_UNUSED, CFG_W'($urandom));
    write_reg(REG_COS, c.cosine);
    write_reg(REG_SIN, c.sine);
    write_reg(REG_HSCALE, c.hscale);
    write_reg(REG_VSCALE, c.vscale);
    write_reg(REG_CX, c.cx);
    write_reg(REG_CY, c.cy);
    // junk above the colour field must be dropped
    write_reg(REG_COLOUR, {(CFG_W - COL_W)'($urandom), c.colour});
    cfg_we_i <= 1'b0;
  endtask

  function automatic plot_cfg_t pick_config(int phase);
    plot_cfg_t c;
    case (phase)
      0: begin
        // extreme values in every field, signs mixed
        c = '{cosine: -16'sd16384, sine: 16'sd16384, hscale: -16'sd32768,
              vscale: 16'sd32767, cx: 16'sd32767, cy: -16'sd32768, colour: 4'd0};
      end
      1: begin
        c = '{cosine: 16'sd0, sine: -16'sd16384, hscale: 16'sd32767,
              vscale: -16'sd32768, cx: -16'sd32768, cy: 16'sd32767, colour: 4'd15};
      end
      default: begin
        c.cosine = CFG_W'($urandom_range(0, 32768)) - 16'sd16384;
        c.sine   = CFG_W'($urandom_range(0, 32768)) - 16'sd16384;
        c.colour = COL_W'($urandom);
        if ($urandom_range(0, 2) == 0) begin
          c.hscale = CFG_W'($urandom);
          c.vscale = CFG_W'($urandom);
          c.cx     = CFG_W'($urandom);
          c.cy     = CFG_W'($urandom);
        end else begin
          // moderate scales and centers keep most pixels unsaturated
          c.hscale = CFG_W'($urandom_range(0, 16383)) - 16'sd8192;
          c.vscale = CFG_W'($urandom_range(0, 16383)) - 16'sd8192;
          c.cx     = CFG_W'($urandom_range(0, 2047)) - 16'sd1024;
          c.cy     = CFG_W'($urandom_range(0, 2047)) - 16'sd1024;
        end
      end
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // pixel side: random ready bursts, one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    pix.ready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        // long stall so the pipeline fills and backs up into seg
        hold_request = 1'b0;
        pix.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        pix.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        pix.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // every pixel beat is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && pix.valid === 1'b1 && pix.ready === 1'b1) begin
      board.check_pixel('{pix.pixel_x, pix.pixel_y, pix.pixel_colour});
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    plot_cfg_t sat_cfg;
    board        = new();
    quiet        = 1'b0;
    hold_request = 1'b0;

    // known values on every input from time zero
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = '0;
    cfg_data_i          = '0;
    seg.valid           = 1'b0;
    seg.start_x         = '0;
    seg.start_y         = '0;
    seg.end_x           = '0;
    seg.end_y           = '0;
    seg.start_tangent_x = '0;
    seg.start_tangent_y = '0;
    seg.end_tangent_x   = '0;
    seg.end_tangent_y   = '0;
    seg.sample_index    = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beats on the reset configuration: identity rotation, unit scale
    send_seg(make_seg(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_seg(make_seg(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 0));
    send_seg(make_seg(-1024, -1024, -1024, -1024, -1024, -1024, -1024, -1024, STEPS));
    send_seg(make_seg(1023, -1024, -1024, 1023, 1023, -1024, 1023, -1024, STEPS / 2));
    send_seg(make_seg(0, 0, 0, 0, -1024, 1023, -1024, 1023, STEPS / 4));
    // sample index past STEPS clamps to the segment end
    send_seg(make_seg(5, -7, 300, -400, 11, 13, -17, 19, STEPS + 1));
    send_seg(make_seg(5, -7, 300, -400, 11, 13, -17, 19, (1 << IN_W) - 1));
    send_seg(make_seg(-3, 3, 1, -1, 1023, -1024, -1024, 1023, 1));
    send_seg(make_seg(-3, 3, 1, -1, 1023, -1024, -1024, 1023, STEPS - 1));
    send_seg(make_seg(-1024, 1023, 1023, -1024, -1024, 1023, 1023, -1024, 3 * STEPS / 4));
    send_seg(make_seg(1, -1, -1, 1, 1, -1, -1, 1, 1000));
    send_seg(make_seg(100, 200, -100, -200, 0, 0, 0, 0, 333));

    // directed saturation: rotation by the largest sine, extreme scales and centers
    wait_drained();
    sat_cfg = '{cosine: 16'sd16384, sine: 16'sd16384, hscale: 16'sd32767,
                vscale: -16'sd32768, cx: 16'sd32767, cy: -16'sd32768, colour: 4'd9};
    program_config(sat_cfg);
    send_seg(make_seg(1023, 1023, 1023, 1023, 0, 0, 0, 0, 0));
    send_seg(make_seg(-1024, -1024, -1024, -1024, 0, 0, 0, 0, STEPS));
    send_seg(make_seg(0, 0, 0, 0, 0, 0, 0, 0, STEPS / 2));
    send_seg(make_seg(-1024, 1023, 1023, -1024, 1023, 1023, -1024, -1024, 700));
    sat_cfg = '{cosine: -16'sd16384, sine: 16'sd0, hscale: 16'sd1,
                vscale: -16'sd1, cx: -16'sd5, cy: 16'sd5, colour: 4'd6};
    wait_drained();
    program_config(sat_cfg);
    send_seg(make_seg(1023, -1024, 7, -7, 0, 0, 0, 0, 0));
    send_seg(make_seg(-1024, 1023, -7, 7, 50, -50, 0, 0, STEPS / 8));

    // random phases, each on its own configuration
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      program_config(pick_config(phase));
      quiet = (phase == PHASES - 1);
      if (phase == PRESSURE_PHASE) begin
        // back-to-back beats against a stalled receiver
        hold_request = 1'b1;
        repeat (PRESSURE_BEATS) send_seg(random_seg());
      end
      repeat (PHASE_BEATS) begin
        if (!quiet && $urandom_range(0, 3) == 0) sender_idle($urandom_range(1, 14));
        send_seg(random_seg());
      end
    end

    // let the pipeline empty, then a little extra for stray beats
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.failures == 0) begin
      $display("tb_hermite_curve_point_plotter: PASS");
    end else begin
      $display("tb_hermite_curve_point_plotter: FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_hermite_curve_point_plotter: FAIL");
    $finish;
  end

endmodule

// ===== hermite_curve_point_plotter.f =====
hw/rtl/hcpp_pkg.sv
hw/rtl/hcpp_stream_if.sv
hw/rtl/hcpp_axis.sv
hw/rtl/hermite_curve_point_plotter.sv
dv/tb_hermite_curve_point_plotter.sv
